// File: src/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, reset disables it.
`define AFSTA_ASSERT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Same-cycle implication.
`define AFSTA_ASSERT_IMPLY(lbl, clk_s, rst_s, pre, post, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) else $error(msg);

`endif

// File: src/afsta_pkg.sv
`default_nettype none

package afsta_pkg;

	localparam int FLOW_ENTRIES_DEF = 4096;
	localparam int COUNTER_BITS_DEF = 48;
	localparam int NUM_CATS         = 13;
	localparam int TOTAL_W          = 48;
	localparam int ID_W             = 12;

	// protocol IDs
	localparam logic [ID_W-1:0] ID_NONE        = 12'd0;
	localparam logic [ID_W-1:0] ID_MSG_CHANGE  = 12'd1;
	localparam logic [ID_W-1:0] ID_HTTP        = 12'd78;
	localparam logic [ID_W-1:0] ID_COMMON      = 12'd1837;
	localparam logic [ID_W-1:0] ID_VOIP        = 12'd1865;
	localparam logic [ID_W-1:0] ID_LOGIN       = 12'd3073;
	localparam logic [ID_W-1:0] ID_TALK        = 12'd3074;
	localparam logic [ID_W-1:0] ID_VOICE_CALL  = 12'd3075;
	localparam logic [ID_W-1:0] ID_VIDEO_CALL  = 12'd3076;
	localparam logic [ID_W-1:0] ID_TEXT        = 12'd3077;
	localparam logic [ID_W-1:0] ID_PICTURE     = 12'd3078;
	localparam logic [ID_W-1:0] ID_HEARTBEAT   = 12'd3079;
	localparam logic [ID_W-1:0] ID_FRIENDS     = 12'd3080;
	localparam logic [ID_W-1:0] ID_VOICE_MSG   = 12'd3081;
	localparam logic [ID_W-1:0] ID_VIDEO_START = 12'd3082;
	localparam logic [ID_W-1:0] ID_VIDEO_END   = 12'd3083;
	localparam logic [ID_W-1:0] ID_AV_SWITCH   = 12'd3084;
	localparam logic [ID_W-1:0] ID_TALK_START  = 12'd3085;
	localparam logic [ID_W-1:0] ID_TALK_END    = 12'd3086;
	localparam logic [ID_W-1:0] ID_LOGOUT      = 12'd3087;
	localparam logic [ID_W-1:0] ID_KEYDOWN     = 12'd3088;

	// message-change signature on payload bytes 7..10
	localparam logic [31:0] SIG_MSG_CHANGE = 32'h0000_0001;
	localparam logic [15:0] SIG_MIN_LEN    = 16'd11;

	localparam logic ACT_CLASSIFY = 1'b0;
	localparam logic ACT_CLEAR    = 1'b1;

	// categories
	localparam logic [3:0] CAT_NONE       = 4'd0;
	localparam logic [3:0] CAT_COMMON     = 4'd1;
	localparam logic [3:0] CAT_LOGIN      = 4'd2;
	localparam logic [3:0] CAT_TEXT       = 4'd3;
	localparam logic [3:0] CAT_PICTURE    = 4'd4;
	localparam logic [3:0] CAT_VOICE_MSG  = 4'd5;
	localparam logic [3:0] CAT_FRIENDS    = 4'd6;
	localparam logic [3:0] CAT_HEARTBEAT  = 4'd7;
	localparam logic [3:0] CAT_TALK       = 4'd8;
	localparam logic [3:0] CAT_VIDEO      = 4'd9;
	localparam logic [3:0] CAT_VOICE_CALL = 4'd10;
	localparam logic [3:0] CAT_VOIP       = 4'd11;
	localparam logic [3:0] CAT_LOGOUT     = 4'd12;
	localparam logic [3:0] CAT_KEYDOWN    = 4'd13;

	typedef struct packed {
		logic            action;
		logic [11:0]     flow_index;
		logic            new_flow;
		logic [ID_W-1:0] proto_id;
		logic [ID_W-1:0] carrier_proto_id;
		logic [ID_W-1:0] flow_proto_id;
		logic [15:0]     payload_len;
		logic [15:0]     packet_bytes;
		logic [31:0]     sig_bytes;
	} req_t;

	typedef struct packed {
		logic [3:0]         category;
		logic [TOTAL_W-1:0] category_total;
		logic               keep_inspecting;
		logic               bypass;
		logic [ID_W-1:0]    flow_state_out;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0] state;
		logic            app_seen;
		logic            long_conn;
	} flow_entry_t;

	typedef struct packed {
		logic [3:0]  cat;
		logic        keep;
		logic        bypass;
		flow_entry_t entry;
	} decision_t;

	function automatic logic [3:0] cat_of(input logic [ID_W-1:0] id);
		case (id)
			ID_COMMON:                              return CAT_COMMON;
			ID_LOGIN:                               return CAT_LOGIN;
			ID_TEXT:                                return CAT_TEXT;
			ID_PICTURE:                             return CAT_PICTURE;
			ID_VOICE_MSG:                           return CAT_VOICE_MSG;
			ID_FRIENDS:                             return CAT_FRIENDS;
			ID_HEARTBEAT:                           return CAT_HEARTBEAT;
			ID_TALK, ID_TALK_START, ID_TALK_END:    return CAT_TALK;
			ID_VIDEO_CALL, ID_VIDEO_START,
			ID_VIDEO_END, ID_AV_SWITCH:             return CAT_VIDEO;
			ID_VOICE_CALL:                          return CAT_VOICE_CALL;
			ID_VOIP:                                return CAT_VOIP;
			ID_LOGOUT:                              return CAT_LOGOUT;
			ID_KEYDOWN:                             return CAT_KEYDOWN;
			default:                                return CAT_NONE;
		endcase
	endfunction

	function automatic logic is_app(input logic [ID_W-1:0] id);
		return id inside {ID_COMMON, ID_VOIP, [ID_LOGIN:ID_KEYDOWN]};
	endfunction

	// call/talk state machine; video and talk sessions only leave on their end ID
	function automatic logic [ID_W-1:0] advance(input logic [ID_W-1:0] st,
	                                            input logic [ID_W-1:0] ev);
		if (st == ID_VIDEO_START)
			return (ev == ID_VIDEO_END) ? ID_NONE : st;
		if (st == ID_TALK_START)
			return (ev == ID_TALK_END) ? ID_NONE : st;
		if (ev == ID_MSG_CHANGE)
			return ID_NONE;
		return ev;
	endfunction

endpackage

`default_nettype wire

// File: src/afsta_ram.sv
`default_nettype none

module afsta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: src/afsta_decide.sv
`default_nettype none

module afsta_decide (
	input  wire afsta_pkg::req_t        item,
	input  wire afsta_pkg::flow_entry_t rd_entry,
	output afsta_pkg::decision_t        dec
);
	import afsta_pkg::*;

	always_comb begin
		flow_entry_t     e;
		logic [ID_W-1:0] st;

		e   = item.new_flow ? '0 : rd_entry;
		st  = e.state;
		dec = '0;

		if (item.action == ACT_CLASSIFY) begin
			if (e.app_seen && !e.long_conn) begin
				// short connection: counted under the caller's flow protocol
				dec.bypass = 1'b1;
				if (item.payload_len != '0)
					dec.cat = cat_of(item.flow_proto_id);
			end else if (is_app(item.proto_id)) begin
				e.app_seen = 1'b1;
				if (item.carrier_proto_id != ID_HTTP)
					e.long_conn = 1'b1;
				dec.keep = 1'b1;
				st       = advance(st, item.proto_id);
				dec.cat  = cat_of(item.proto_id);
			end else if (e.app_seen && e.long_conn) begin
				if (item.payload_len >= SIG_MIN_LEN && item.sig_bytes == SIG_MSG_CHANGE)
					st = advance(st, ID_MSG_CHANGE);
				dec.cat  = cat_of((st != ID_NONE) ? st : ID_COMMON);
				dec.keep = 1'b1;
			end
			e.state   = st;
			dec.entry = e;
		end
	end

endmodule

`default_nettype wire

// File: src/afsta_counters.sv
`default_nettype none

module afsta_counters #(
	parameter int COUNTER_BITS = afsta_pkg::COUNTER_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    clear,
	input  wire logic [3:0]              cat,
	input  wire logic [15:0]             bytes,
	output logic      [COUNTER_BITS-1:0] total
);
	import afsta_pkg::*;

	localparam int IDX_W = $clog2(NUM_CATS);

	logic [COUNTER_BITS-1:0] cnt_q [NUM_CATS];
	logic [IDX_W-1:0]        idx;
	logic                    hit;
	logic [COUNTER_BITS-1:0] cur;

	assign hit   = cat inside {[CAT_COMMON:CAT_KEYDOWN]};
	assign idx   = IDX_W'(cat - CAT_COMMON);
	assign cur   = hit ? cnt_q[idx] : '0;
	assign total = cur + COUNTER_BITS'(bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CATS; i++)
				cnt_q[i] <= '0;
		end else if (en && clear) begin
			for (int i = 0; i < NUM_CATS; i++)
				cnt_q[i] <= '0;
		end else if (en && hit) begin
			cnt_q[idx] <= total;
		end
	end

endmodule

`default_nettype wire

// File: src/app_flow_state_traffic_accounting.sv
// A request beat registers the request and its index quotient, s0 reduces the index and
// reads the flow RAM, s1 decides, writes back and registers the response (held while stalled).
// A new request is taken only once s0 and s1 are empty, so the flow RAM read-modify-write ends first.
// Reset: handshake state cleared and all category counters zeroed; flow RAM is not
// initialized, an entry becomes defined once a new_flow request writes it.
`default_nettype none

module app_flow_state_traffic_accounting #(
	parameter int FLOW_ENTRIES = afsta_pkg::FLOW_ENTRIES_DEF,
	parameter int COUNTER_BITS = afsta_pkg::COUNTER_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire afsta_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output afsta_pkg::rsp_t      rsp
);
	import afsta_pkg::*;

	localparam int    AW          = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int    RECIP_SHIFT = 24;
	// reciprocal is exact for 12-bit indices up to 4096 entries; larger tables never wrap
	localparam longint RECIP = ((64'd1 << RECIP_SHIFT) + FLOW_ENTRIES - 1) / FLOW_ENTRIES;

	logic        s0_valid_q, s1_valid_q, rsp_valid_q;
	req_t        req_s0, req_s1;
	logic [11:0] quo_s0;
	logic [AW-1:0] idx_s1;
	rsp_t        rsp_q;

	logic          accept, s1_adv;
	logic [36:0]   prod;
	logic [31:0]   qn;
	logic [11:0]   rem;
	logic [AW-1:0] addr_s0;
	logic [$bits(flow_entry_t)-1:0] rd_raw;
	flow_entry_t   rd_entry;
	decision_t     dec;
	logic [COUNTER_BITS-1:0] total;

	assign req_ready = !s0_valid_q && !s1_valid_q;
	assign accept    = req_valid && req_ready;
	assign s1_adv    = s1_valid_q && (!rsp_valid_q || rsp_ready);

	// flow_index mod FLOW_ENTRIES: quotient on accept, remainder in s0
	assign prod    = 37'(req.flow_index) * 37'(RECIP);
	assign qn      = 32'(quo_s0) * 32'(FLOW_ENTRIES);
	assign rem     = 12'(32'(req_s0.flow_index) - qn);
	assign addr_s0 = AW'(rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_valid_q  <= 1'b0;
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			s0_valid_q <= accept;
			if (s0_valid_q)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;
			if (s1_adv)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s0 <= req;
			quo_s0 <= (FLOW_ENTRIES < 4096) ? prod[RECIP_SHIFT +: 12] : '0;
		end
		if (s0_valid_q) begin
			req_s1 <= req_s0;
			idx_s1 <= addr_s0;
		end
		if (s1_adv) begin
			rsp_q.category        <= dec.cat;
			rsp_q.category_total  <= (dec.cat == CAT_NONE) ? '0 : TOTAL_W'(total);
			rsp_q.keep_inspecting <= dec.keep;
			rsp_q.bypass          <= dec.bypass;
			rsp_q.flow_state_out  <= dec.entry.state;
		end
	end

	afsta_ram #(
		.WIDTH ($bits(flow_entry_t)),
		.DEPTH (FLOW_ENTRIES)
	) u_flow_ram (
		.clk   (clk),
		.we    (s1_adv && req_s1.action == ACT_CLASSIFY),
		.waddr (idx_s1),
		.wdata (dec.entry),
		.re    (s0_valid_q),
		.raddr (addr_s0),
		.rdata (rd_raw)
	);

	assign rd_entry = rd_raw;

	afsta_decide u_decide (
		.item     (req_s1),
		.rd_entry (rd_entry),
		.dec      (dec)
	);

	afsta_counters #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (s1_adv),
		.clear  (req_s1.action == ACT_CLEAR),
		.cat    (dec.cat),
		.bytes  (req_s1.packet_bytes),
		.total  (total)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: src/afsta_checker.sv
`default_nettype none
`include "assert_macros.svh"

module afsta_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            req_valid,
	input wire logic            req_ready,
	input wire afsta_pkg::req_t req,
	input wire logic            rsp_valid,
	input wire logic            rsp_ready,
	input wire afsta_pkg::rsp_t rsp
);
	import afsta_pkg::*;

	`AFSTA_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response beat changed while stalled")
	`AFSTA_ASSERT(a_one_in_flight, clk, arst_n, req_valid && req_ready |=> !req_ready, "second request taken while flow entry in flight")
	`AFSTA_ASSERT_IMPLY(a_none_zero, clk, arst_n, rsp_valid && rsp.category == CAT_NONE, rsp.category_total == '0, "nonzero total with no category")
	`AFSTA_ASSERT_IMPLY(a_bypass_no_keep, clk, arst_n, rsp_valid && rsp.bypass, !rsp.keep_inspecting, "bypass beat asks to keep inspecting")
	`AFSTA_ASSERT_IMPLY(a_cat_range, clk, arst_n, rsp_valid, rsp.category <= CAT_KEYDOWN, "category code out of range")

endmodule

bind app_flow_state_traffic_accounting afsta_checker u_checker (.*);

`default_nettype wire

// File: dv/app_flow_state_traffic_accounting_tb.sv
`default_nettype none

module app_flow_state_traffic_accounting_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import afsta_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	app_flow_state_traffic_accounting dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	req_t packet_q[$];
	rsp_t tally_q[$];
	rsp_t head_tally;

	// flow entries the stimulus has already opened with new_flow
	bit flow_live [4096];

	// shadow of the block's flow table and category counters
	logic [ID_W-1:0]    shadow_state [4096];
	bit                 shadow_seen  [4096];
	bit                 shadow_long  [4096];
	logic [TOTAL_W-1:0] cat_bytes    [NUM_CATS];

	int mismatch_cnt = 0;
	int rcv_cnt = 0;
	int send_gap = 0;
	int send_quiet = 0;
	int rcv_gap = 0;
	int rcv_quiet = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;

	function automatic logic [3:0] category_for(logic [ID_W-1:0] id);
		if (id == ID_COMMON)
			return CAT_COMMON;
		if (id == ID_VOIP)
			return CAT_VOIP;
		unique case (id)
			ID_LOGIN:      return CAT_LOGIN;
			ID_TEXT:       return CAT_TEXT;
			ID_PICTURE:    return CAT_PICTURE;
			ID_VOICE_MSG:  return CAT_VOICE_MSG;
			ID_FRIENDS:    return CAT_FRIENDS;
			ID_HEARTBEAT:  return CAT_HEARTBEAT;
			ID_VOICE_CALL: return CAT_VOICE_CALL;
			ID_LOGOUT:     return CAT_LOGOUT;
			ID_KEYDOWN:    return CAT_KEYDOWN;
			ID_TALK, ID_TALK_START, ID_TALK_END: return CAT_TALK;
			ID_VIDEO_CALL, ID_VIDEO_START, ID_VIDEO_END, ID_AV_SWITCH: return CAT_VIDEO;
			default:       return CAT_NONE;
		endcase
	endfunction

	function automatic bit app_id(logic [ID_W-1:0] id);
		return (id == ID_COMMON) || (id == ID_VOIP) || (id >= ID_LOGIN && id <= ID_KEYDOWN);
	endfunction

	function automatic logic [ID_W-1:0] next_state(logic [ID_W-1:0] st, logic [ID_W-1:0] ev);
		// open video/talk sessions are sticky until their own end ID
		if (st == ID_VIDEO_START || st == ID_TALK_START) begin
			if ((st == ID_VIDEO_START && ev == ID_VIDEO_END) ||
			    (st == ID_TALK_START && ev == ID_TALK_END))
				return ID_NONE;
			return st;
		end
		return (ev == ID_MSG_CHANGE) ? ID_NONE : ev;
	endfunction

	function automatic rsp_t tally_packet(req_t p);
		rsp_t r;
		logic [11:0] fi;
		logic [ID_W-1:0] st;
		logic [3:0] cat;
		r = '0;
		if (p.action == ACT_CLEAR) begin
			for (int i = 0; i < NUM_CATS; i++)
				cat_bytes[i] = '0;
			return r;
		end
		fi = p.flow_index;
		if (p.new_flow) begin
			shadow_state[fi] = ID_NONE;
			shadow_seen[fi] = 1'b0;
			shadow_long[fi] = 1'b0;
		end
		st = shadow_state[fi];
		cat = CAT_NONE;
		if (shadow_seen[fi] && !shadow_long[fi]) begin
			// short connection: counted by the recorded flow protocol
			r.bypass = 1'b1;
			if (p.payload_len != 16'd0)
				cat = category_for(p.flow_proto_id);
		end else if (app_id(p.proto_id)) begin
			shadow_seen[fi] = 1'b1;
			if (p.carrier_proto_id != ID_HTTP)
				shadow_long[fi] = 1'b1;
			r.keep_inspecting = 1'b1;
			st = next_state(st, p.proto_id);
			cat = category_for(p.proto_id);
		end else if (shadow_seen[fi] && shadow_long[fi]) begin
			if (p.payload_len >= SIG_MIN_LEN && p.sig_bytes == SIG_MSG_CHANGE)
				st = next_state(st, ID_MSG_CHANGE);
			cat = category_for((st != ID_NONE) ? st : ID_COMMON);
			r.keep_inspecting = 1'b1;
		end
		shadow_state[fi] = st;
		if (cat != CAT_NONE) begin
			cat_bytes[cat - 1] = cat_bytes[cat - 1] + p.packet_bytes;
			r.category_total = cat_bytes[cat - 1];
		end
		r.category = cat;
		r.flow_state_out = st;
		return r;
	endfunction

	// mostly back-to-back or short gaps, a few long ones, and quiet stretches with none
	function automatic int pick_gap(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			quiet = $urandom_range(30, 80);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ID_W-1:0] pick_app_id();
		int r;
		r = $urandom_range(0, 17);
		if (r == 0)
			return ID_COMMON;
		if (r == 1)
			return ID_VOIP;
		return ID_LOGIN + ID_W'(r - 2);
	endfunction

	task automatic queue_packet(logic [11:0] idx, logic nf, logic [ID_W-1:0] pid,
	                            logic [ID_W-1:0] carrier, logic [ID_W-1:0] fpid,
	                            logic [15:0] plen, logic [15:0] nbytes, logic [31:0] sig);
		req_t p;
		p.action = ACT_CLASSIFY;
		p.flow_index = idx;
		// a flow entry is never read before new_flow has defined it
		p.new_flow = nf | !flow_live[idx];
		p.proto_id = pid;
		p.carrier_proto_id = carrier;
		p.flow_proto_id = fpid;
		p.payload_len = plen;
		p.packet_bytes = nbytes;
		p.sig_bytes = sig;
		flow_live[idx] = 1'b1;
		packet_q.push_back(p);
	endtask

	task automatic queue_clear();
		req_t p;
		p = req_t'({$urandom, $urandom, $urandom, $urandom});
		p.action = ACT_CLEAR;
		packet_q.push_back(p);
	endtask

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("mismatch on %s: expected %0h, got %0h", what, want, got);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready)
				tally_q.push_back(tally_packet(req));
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (packet_q.size() > 0) begin
					req <= packet_q.pop_front();
					req_valid <= 1'b1;
					send_gap = pick_gap(send_quiet);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rcv_cnt <= rcv_cnt + 1;
				if (tally_q.size() == 0) begin
					note_mismatch("unexpected result beat", 64'd0, 64'd1);
				end else begin
					head_tally = tally_q.pop_front();
					if (rsp.category !== head_tally.category)
						note_mismatch("category", head_tally.category, rsp.category);
					if (rsp.category_total !== head_tally.category_total)
						note_mismatch("category_total", head_tally.category_total,
						              rsp.category_total);
					if (rsp.keep_inspecting !== head_tally.keep_inspecting)
						note_mismatch("keep_inspecting", head_tally.keep_inspecting,
						              rsp.keep_inspecting);
					if (rsp.bypass !== head_tally.bypass)
						note_mismatch("bypass", head_tally.bypass, rsp.bypass);
					if (rsp.flow_state_out !== head_tally.flow_state_out)
						note_mismatch("flow_state_out", head_tally.flow_state_out,
						              rsp.flow_state_out);
				end
			end
			if (hold_cnt > 0) begin
				rsp_ready <= 1'b0;
			end else if (rcv_gap > 0) begin
				rcv_gap--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				rcv_gap = pick_gap(rcv_quiet);
			end
		end
	end

	// one long receiver hold-off so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && rcv_cnt >= 250) begin
			hold_cnt <= 300;
			hold_done <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	initial begin
		int r;
		logic [11:0] idx;
		logic [11:0] pool [12];
		logic [ID_W-1:0] pid;
		logic [ID_W-1:0] carrier;
		logic [ID_W-1:0] fpid;
		logic [15:0] plen;
		logic [31:0] sig;

		// long connection on flow 0: walk the video and talk session machine
		queue_packet(12'd0, 1'b1, ID_COMMON, 12'd0, 12'd0, 16'd0, 16'd0, 32'd0);
		queue_packet(12'd0, 1'b0, ID_VIDEO_START, 12'd4095, 12'd0, 16'd100, 16'hFFFF, 32'd0);
		queue_packet(12'd0, 1'b0, ID_NONE, 12'd0, 12'd0, 16'd11, 16'd40, SIG_MSG_CHANGE);
		queue_packet(12'd0, 1'b0, ID_TALK_START, 12'd0, 12'd0, 16'd20, 16'd50, 32'd0);
		queue_packet(12'd0, 1'b0, ID_VIDEO_END, 12'd0, 12'd0, 16'd20, 16'd60, 32'd0);
		queue_packet(12'd0, 1'b0, 12'd4095, 12'd0, 12'd0, 16'd20, 16'd70, 32'd0);
		queue_packet(12'd0, 1'b0, ID_TALK_START, 12'd0, 12'd0, 16'd20, 16'd80, 32'd0);
		queue_packet(12'd0, 1'b0, ID_VIDEO_END, 12'd0, 12'd0, 16'd20, 16'd90, 32'd0);
		queue_packet(12'd0, 1'b0, ID_NONE, 12'd0, 12'd0, 16'd11, 16'd10, SIG_MSG_CHANGE);
		queue_packet(12'd0, 1'b0, ID_TALK_END, 12'd0, 12'd0, 16'd20, 16'd11, 32'd0);
		queue_packet(12'd0, 1'b0, ID_TEXT, 12'd0, 12'd0, 16'd20, 16'd12, 32'd0);
		// signature only counts from an 11-byte payload up
		queue_packet(12'd0, 1'b0, ID_NONE, 12'd0, 12'd0, 16'd10, 16'd13, SIG_MSG_CHANGE);
		queue_packet(12'd0, 1'b0, ID_NONE, 12'd0, 12'd0, 16'd11, 16'd14, SIG_MSG_CHANGE);
		queue_packet(12'd0, 1'b0, 12'd5, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		// HTTP carrier makes a short connection, later beats bypass
		queue_packet(12'd4095, 1'b1, ID_VOIP, ID_HTTP, 12'd0, 16'd30, 16'd100, 32'd0);
		queue_packet(12'd4095, 1'b0, ID_LOGIN, 12'd0, ID_KEYDOWN, 16'd0, 16'd100, 32'd0);
		queue_packet(12'd4095, 1'b0, 12'd0, 12'd0, ID_KEYDOWN, 16'd1, 16'd200, 32'd0);
		queue_packet(12'd4095, 1'b0, ID_LOGIN, 12'd0, 12'd5, 16'd100, 16'd300, 32'd0);
		// never saw the app: nothing counted
		queue_packet(12'd2048, 1'b1, ID_NONE, 12'd0, ID_COMMON, 16'd50, 16'd400, 32'd1);
		queue_clear();
		queue_packet(12'd0, 1'b0, ID_LOGOUT, 12'd0, 12'd0, 16'd20, 16'd500, 32'd0);
		queue_packet(12'd0, 1'b1, ID_TALK, ID_HTTP, 12'd0, 16'd20, 16'd600, 32'd0);
		queue_packet(12'd0, 1'b0, ID_TALK, 12'd0, ID_AV_SWITCH, 16'd20, 16'd700, 32'd0);

		foreach (pool[i])
			pool[i] = 12'($urandom);
		for (int n = 0; n < 900; n++) begin
			if ($urandom_range(0, 99) < 2) begin
				queue_clear();
			end else begin
				idx = ($urandom_range(0, 9) == 0) ? 12'($urandom) : pool[$urandom_range(0, 11)];
				r = $urandom_range(0, 99);
				pid = (r < 55) ? pick_app_id() : (r < 65) ? 12'($urandom) :
				      (r < 85) ? ID_NONE : 12'($urandom_range(0, 1000));
				carrier = ($urandom_range(0, 99) < 15) ? ID_HTTP : 12'($urandom);
				fpid = ($urandom_range(0, 9) < 7) ? pick_app_id() : 12'($urandom);
				r = $urandom_range(0, 9);
				plen = (r == 0) ? 16'd0 : (r == 1) ? 16'd10 : (r == 2) ? 16'd11 : 16'($urandom);
				sig = ($urandom_range(0, 9) < 3) ? SIG_MSG_CHANGE : 32'($urandom);
				queue_packet(idx, $urandom_range(0, 99) < 5, pid, carrier, fpid, plen,
				             16'($urandom), sig);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (packet_q.size() != 0 || req_valid || tally_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_cnt == 0 && tally_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: app_flow_state_traffic_accounting.f
+incdir+src
src/afsta_pkg.sv
src/afsta_ram.sv
src/afsta_decide.sv
src/afsta_counters.sv
src/app_flow_state_traffic_accounting.sv
src/afsta_checker.sv
dv/app_flow_state_traffic_accounting_tb.sv
